// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SSR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent on the following clock edge
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Types and constants shared by the sandpile ring step controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package ssr_pkg;

   // item field widths
   localparam int SITE_W      = 10;
   localparam int AMOUNT_W    = 16;
   localparam int HSUM_W      = 40;
   localparam int QSUM_W      = 63;
   localparam int COUNT_W     = 32;
   localparam int RING_SIZE_W = 11;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP    = 1'b1;
   localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 11'd1000;
   localparam logic [CSR_DATA_W-1:0]  WARMUP_RESET    = 32'd1000000;

   // action codes
   localparam logic [1:0] ACT_DEPOSIT = 2'd0;
   localparam logic [1:0] ACT_TOPPLE  = 2'd1;
   localparam logic [1:0] ACT_SWEEP   = 2'd2;

   typedef struct packed {
      logic [1:0]          action;
      logic [SITE_W-1:0]   site;
      logic [AMOUNT_W-1:0] amount;
      logic                first_goes_right;
      logic                second_goes_right;
   } req_item_type;

   typedef struct packed {
      logic               toppled;
      logic               sample_taken;
      logic [HSUM_W-1:0]  height_sum;
      logic [QSUM_W-1:0]  square_sum;
      logic [COUNT_W-1:0] sample_count;
   } rsp_item_type;

   // memory read address source
   typedef enum logic [1:0] {
      RD_REQ = 2'd0,
      RD_TA  = 2'd1,
      RD_TB  = 2'd2
   } rd_sel_type;

   // memory write source
   typedef enum logic [2:0] {
      WR_NONE    = 3'd0,
      WR_CLEAR   = 3'd1,
      WR_DEPOSIT = 3'd2,
      WR_SITE    = 3'd3,
      WR_TA      = 3'd4,
      WR_TB      = 3'd5
   } wr_sel_type;

   typedef struct packed {
      logic       accept;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       count_sweep;
      logic       sq_load;
      logic       acc;
      logic       rsp;
      logic       rsp_toppled;
      logic       rsp_sampled;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [1:0] action;
      logic       site_ok;
      logic       active;
      logic       single_tgt;
      logic       sample_due;
   } ctrl_status_type;

endpackage

// ===== rtl/ssr_dp.sv =====
// ----------------------------------------------------------------------------
// ssr_dp
// Datapath: height memory with clearing sweep, neighbor arithmetic,
// saturating updates, sweep counter, sample accumulators and result register.
// ----------------------------------------------------------------------------
module ssr_dp import ssr_pkg::*; #(
   parameter int MAX_SITES   = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_item_type          req_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  ctrl_cmd_type          cmd_i,
   output ctrl_status_type       status_o,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item
);

`include "assert_macros.svh"

   localparam int AW   = $clog2(MAX_SITES);
   localparam int NW   = $clog2(MAX_SITES + 1);
   localparam int CW   = (NW > RING_SIZE_W) ? NW : RING_SIZE_W;
   localparam int HB   = HEIGHT_BITS;
   localparam int HB1  = HEIGHT_BITS + 1;
   localparam int DW   = ((HEIGHT_BITS > AMOUNT_W) ? HEIGHT_BITS : AMOUNT_W) + 1;
   localparam int QW   = 2 * HEIGHT_BITS;
   localparam int AccW = ((QW > QSUM_W) ? QW : QSUM_W) + 1;
   localparam logic [HB-1:0]     HMAX      = '1;
   localparam logic [HSUM_W-1:0] HSUM_MAX  = '1;
   localparam logic [QSUM_W-1:0] QSUM_MAX  = '1;
   localparam logic [COUNT_W-1:0] CNT_MAX  = '1;

   logic [RING_SIZE_W-1:0] ring_size_ff;
   logic [CSR_DATA_W-1:0]  warmup_ff;
   req_item_type           item_ff;
   logic [HB-1:0]          heights_ff [MAX_SITES];
   logic [HB-1:0]          rd_data_ff;
   logic [AW-1:0]          clr_cnt_ff;
   logic [COUNT_W-1:0]     sweep_cnt_ff;
   logic [HB-1:0]          h_samp_ff;
   logic [QW-1:0]          sq_ff;
   logic [HSUM_W-1:0]      hsum_ff;
   logic [QSUM_W-1:0]      qsum_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   rsp_valid_ff;
   logic                   toppled_ff;
   logic                   sampled_ff;

   logic [CW-1:0]   ring_ext;
   logic [CW-1:0]   n_eff;
   logic [CW-1:0]   site_ext;
   logic [CW-1:0]   left_ext;
   logic [CW-1:0]   right_ext;
   logic [CW-1:0]   req_site_ext;
   logic [AW-1:0]   site_idx;
   logic [AW-1:0]   left_idx;
   logic [AW-1:0]   right_idx;
   logic [AW-1:0]   ta_idx;
   logic [AW-1:0]   tb_idx;
   logic [AW-1:0]   req_addr;
   logic            site_ok;
   logic            single_tgt;
   logic [DW-1:0]   dep_sum;
   logic [HB-1:0]   dep_val;
   logic [HB1-1:0]  inc_sum;
   logic [HB-1:0]   inc_val;
   logic [HB-1:0]   sub_val;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [HB-1:0]   mem_wdata;
   logic [AW-1:0]   mem_raddr;
   logic [HSUM_W:0] hsum_add;
   logic [AccW-1:0] qsum_add;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_SIZE_RESET;
         warmup_ff    <= WARMUP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RING_SIZE: ring_size_ff <= csr_wdata[RING_SIZE_W-1:0];
            CSR_WARMUP:    warmup_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective ring length, clamped to the legal span
   assign ring_ext = CW'(ring_size_ff);
   always_comb begin
      if (ring_ext < CW'(2)) begin
         n_eff = CW'(2);
      end else if (ring_ext > CW'(MAX_SITES)) begin
         n_eff = CW'(MAX_SITES);
      end else begin
         n_eff = ring_ext;
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (cmd_i.accept) begin
         item_ff <= req_item;
      end
   end

   // site check and neighbors with wrap
   assign site_ext   = CW'(item_ff.site);
   assign site_ok    = site_ext < n_eff;
   assign left_ext   = (site_ext == '0) ? n_eff - CW'(1) : site_ext - CW'(1);
   assign right_ext  = (site_ext + CW'(1) == n_eff) ? '0 : site_ext + CW'(1);
   assign site_idx   = site_ext[AW-1:0];
   assign left_idx   = left_ext[AW-1:0];
   assign right_idx  = right_ext[AW-1:0];
   assign ta_idx     = item_ff.first_goes_right ? right_idx : left_idx;
   assign tb_idx     = item_ff.second_goes_right ? right_idx : left_idx;
   // both grains land on one site: same direction or a ring of two
   assign single_tgt = (left_ext == right_ext) ||
                       (item_ff.first_goes_right == item_ff.second_goes_right);

   // read address of an incoming item, site zero for a sweep end
   assign req_site_ext = CW'(req_item.site);
   assign req_addr     = (req_item.action == ACT_SWEEP) ? '0 : req_site_ext[AW-1:0];

   // saturating height updates
   assign dep_sum = DW'(rd_data_ff) + DW'(item_ff.amount);
   assign dep_val = (dep_sum > DW'(HMAX)) ? HMAX : dep_sum[HB-1:0];
   assign inc_sum = HB1'(rd_data_ff) +
                    (((cmd_i.wr_sel == WR_TA) && single_tgt) ? HB1'(2) : HB1'(1));
   assign inc_val = (inc_sum > HB1'(HMAX)) ? HMAX : inc_sum[HB-1:0];
   assign sub_val = rd_data_ff - HB'(2);

   // memory write source
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = site_idx;
      mem_wdata = sub_val;
      unique case (cmd_i.wr_sel)
         WR_NONE: ;
         WR_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
         end
         WR_DEPOSIT: begin
            mem_we    = 1'b1;
            mem_wdata = dep_val;
         end
         WR_SITE: begin
            mem_we = 1'b1;
         end
         WR_TA: begin
            mem_we    = 1'b1;
            mem_waddr = ta_idx;
            mem_wdata = inc_val;
         end
         WR_TB: begin
            mem_we    = 1'b1;
            mem_waddr = tb_idx;
            mem_wdata = inc_val;
         end
         default: ;
      endcase
   end

   // memory read address source
   always_comb begin
      unique case (cmd_i.rd_sel)
         RD_REQ:  mem_raddr = req_addr;
         RD_TA:   mem_raddr = ta_idx;
         RD_TB:   mem_raddr = tb_idx;
         default: mem_raddr = req_addr;
      endcase
   end

   // height memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heights_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= heights_ff[mem_raddr];
   end

   // clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd_i.wr_sel == WR_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   // sweep counter, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd_i.count_sweep && (sweep_cnt_ff != CNT_MAX)) begin
         sweep_cnt_ff <= sweep_cnt_ff + COUNT_W'(1);
      end
   end

   // square of the sampled height
   always_ff @(posedge clock) begin
      if (cmd_i.sq_load) begin
         h_samp_ff <= rd_data_ff;
         sq_ff     <= QW'(rd_data_ff) * QW'(rd_data_ff);
      end
   end

   // sample accumulators, saturating
   assign hsum_add = (HSUM_W+1)'(hsum_ff) + (HSUM_W+1)'(h_samp_ff);
   assign qsum_add = AccW'(qsum_ff) + AccW'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hsum_ff  <= '0;
         qsum_ff  <= '0;
         count_ff <= '0;
      end else if (cmd_i.acc) begin
         hsum_ff  <= (hsum_add > (HSUM_W+1)'(HSUM_MAX)) ? HSUM_MAX : hsum_add[HSUM_W-1:0];
         qsum_ff  <= (qsum_add > AccW'(QSUM_MAX)) ? QSUM_MAX : qsum_add[QSUM_W-1:0];
         if (count_ff != CNT_MAX) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_i.rsp;
      end
      toppled_ff <= cmd_i.rsp_toppled;
      sampled_ff <= cmd_i.rsp_sampled;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_item.toppled      = toppled_ff;
   assign rsp_item.sample_taken = sampled_ff;
   assign rsp_item.height_sum   = hsum_ff;
   assign rsp_item.square_sum   = qsum_ff;
   assign rsp_item.sample_count = count_ff;

   // status to the controller
   assign status_o.clear_done = (clr_cnt_ff == AW'(MAX_SITES - 1));
   assign status_o.action     = item_ff.action;
   assign status_o.site_ok    = site_ok;
   assign status_o.active     = rd_data_ff > HB'(1);
   assign status_o.single_tgt = single_tgt;
   assign status_o.sample_due = sweep_cnt_ff > warmup_ff;

   // grains never go back to the site that toppled
   `SSR_ASSERT(a_target_not_site, (cmd_i.wr_sel != WR_TA) || (ta_idx != site_idx), "grain target equals toppled site")

endmodule

// ===== rtl/ssr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssr_ctrl
// Controller: sequences the clearing sweep, item accept, memory reads and
// writes, sample accumulation and the result strobe.
// ----------------------------------------------------------------------------
module ssr_ctrl import ssr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ctrl_status_type status_i,
   output ctrl_cmd_type    cmd_o
);

`include "assert_macros.svh"

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_TGT_A = 6'b001000,
      ST_TGT_B = 6'b010000,
      ST_ACC   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd_o        = '0;
      cmd_o.rd_sel = RD_REQ;
      cmd_o.wr_sel = WR_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd_o.wr_sel = WR_CLEAR;
            if (status_i.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_o.accept = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            unique case (status_i.action)
               ACT_DEPOSIT: begin
                  if (status_i.site_ok) begin
                     cmd_o.wr_sel = WR_DEPOSIT;
                  end
                  cmd_o.rsp = 1'b1;
                  state_in  = ST_IDLE;
               end
               ACT_TOPPLE: begin
                  if (status_i.site_ok && status_i.active) begin
                     cmd_o.wr_sel = WR_SITE;
                     cmd_o.rd_sel = RD_TA;
                     state_in     = ST_TGT_A;
                  end else begin
                     cmd_o.rsp = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end
               ACT_SWEEP: begin
                  cmd_o.count_sweep = 1'b1;
                  if (status_i.sample_due) begin
                     cmd_o.sq_load = 1'b1;
                     state_in      = ST_ACC;
                  end else begin
                     cmd_o.rsp = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end
               default: begin
                  cmd_o.rsp = 1'b1;
                  state_in  = ST_IDLE;
               end
            endcase
         end
         ST_TGT_A: begin
            cmd_o.wr_sel = WR_TA;
            if (status_i.single_tgt) begin
               cmd_o.rsp         = 1'b1;
               cmd_o.rsp_toppled = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               cmd_o.rd_sel = RD_TB;
               state_in     = ST_TGT_B;
            end
         end
         ST_TGT_B: begin
            cmd_o.wr_sel      = WR_TB;
            cmd_o.rsp         = 1'b1;
            cmd_o.rsp_toppled = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_ACC: begin
            cmd_o.acc         = 1'b1;
            cmd_o.rsp         = 1'b1;
            cmd_o.rsp_sampled = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // an accepted item is evaluated next
   `SSR_ASSERT_NEXT(a_accept_eval, start && !busy, state_ff == ST_EVAL, "accept did not enter eval")
   // one result strobe per item, never back to back
   `SSR_ASSERT_NEXT(a_rsp_single, cmd_o.rsp, !cmd_o.rsp, "result strobe repeated")
   // the second grain follows the first
   `SSR_ASSERT(a_tgt_b_order, (state_ff != ST_TGT_B) || $past(state_ff == ST_TGT_A), "second target out of order")

endmodule

// ===== rtl/stochastic_sandpile_ring_step.sv =====
// Flow: accept, then eval, which strobes the result for a deposit, plain sweep end or
// an inactive topple; a one-target topple goes on through target A, a sampled sweep
// end through accumulate, a two-target topple through targets A and B. The strobe is
// registered, and the next item is taken in the strobe cycle. The height memory does
// one read and one write a cycle. Reset: synchronous; busy is high while the memory
// is cleared. The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// stochastic_sandpile_ring_step
// Manna sandpile on a ring of sites: deposits, topple attempts with directions set by
// the item, and sweep ends that sample the height of site zero after the warmup.
// ----------------------------------------------------------------------------
module stochastic_sandpile_ring_step import ssr_pkg::*; #(
   parameter int MAX_SITES   = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   ssr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .status_i (status),
      .cmd_o    (cmd)
   );

   // heights, sums and result register
   ssr_dp #(
      .MAX_SITES   (MAX_SITES),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_i     (cmd),
      .status_o  (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
